### rtl/gsbp_pkg.sv
// ----------------------------------------------------------------------------
// gsbp_pkg
// Shared constants for the gshare branch predictor: table geometry defaults,
// configuration register indexes and reset values, counter codes.
// ----------------------------------------------------------------------------
`default_nettype none

package gsbp_pkg;

	// Default table index width (table holds 2**MAX_INDEX_BITS counters)
	localparam int unsigned MAX_INDEX_BITS_DEF = 12;

	// Configuration port
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 4;

	localparam logic [CFG_INDEX_W-1:0] CFG_REG_INDEX_BITS   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_REG_HISTORY_BITS = 2'd1;

	localparam logic [CFG_DATA_W-1:0] INDEX_BITS_RST   = 4'd12;
	localparam logic [CFG_DATA_W-1:0] HISTORY_BITS_RST = 4'd8;

	// Two-bit saturating counter codes
	localparam logic [1:0] CTR_STRONG_NT = 2'd0;
	localparam logic [1:0] CTR_WEAK_T    = 2'd2;
	localparam logic [1:0] CTR_STRONG_T  = 2'd3;

endpackage

`default_nettype wire

### rtl/gsbp_table.sv
// ----------------------------------------------------------------------------
// gsbp_table
// Counter table: one synchronous read port with registered data, one write
// port, and a clearing sweep after reset that sets every entry to weakly
// taken, one entry per cycle, while busy is high.
// ----------------------------------------------------------------------------
`default_nettype none

module gsbp_table #(
	parameter int unsigned AW = gsbp_pkg::MAX_INDEX_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [1:0]    rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [1:0]    wr_data,
	output logic               busy
);

	localparam int unsigned DEPTH = 1 << AW;

	logic [1:0]    ctr_mem_q [DEPTH];
	logic [1:0]    rd_data_q;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [1:0]    mem_wd;

	// Sweep the table after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == {AW{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// Clearing sweep owns the write port while busy
	always_comb begin
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_addr_q;
			mem_wd = gsbp_pkg::CTR_WEAK_T;
		end else begin
			mem_we = wr_en;
			mem_wa = wr_addr;
			mem_wd = wr_data;
		end
	end

	// Memory array: write and registered read; read returns old data on collision
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ctr_mem_q[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_data_q <= ctr_mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_busy_q;

endmodule

`default_nettype wire

### rtl/gshare_branch_predictor.sv
// ----------------------------------------------------------------------------
// gshare_branch_predictor
// Gshare predictor trained on resolved branches: predicts from a 2-bit
// counter selected by address XOR global history, then updates it.
// ----------------------------------------------------------------------------
// Takes one resolved branch per clock cycle unless the table sweep or output
// back-pressure holds in_ready low; results pass stage 1 and the output register.
// The rate is set by the counter table, a single memory with one read and one
// write port: a counter is read in the cycle its branch is accepted and written
// back as it leaves stage 1; a forwarding register covers a branch that hits the
// entry written in the same cycle it was read. After reset the table is swept to
// weakly taken, one entry per cycle, over 2**MAX_INDEX_BITS entries (4096 at the
// default); in_ready stays low meanwhile, but configuration writes are taken.
// Write configuration only while the block is idle. Totals saturate at all ones.
`default_nettype none

module gshare_branch_predictor #(
	parameter int unsigned MAX_INDEX_BITS = gsbp_pkg::MAX_INDEX_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [gsbp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [gsbp_pkg::CFG_DATA_W-1:0]  cfg_data,
	// resolved branch in
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [31:0]                      branch_address,
	input  wire logic                             taken,
	// prediction result out
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  predicted_taken,
	output logic                                  prediction_correct,
	output logic [31:0]                           branch_total,
	output logic [31:0]                           correct_total
);

	localparam int unsigned AW = MAX_INDEX_BITS;
	localparam int unsigned IW = $clog2(MAX_INDEX_BITS + 1);
	localparam int unsigned CW = (IW > gsbp_pkg::CFG_DATA_W) ? IW : gsbp_pkg::CFG_DATA_W;

	// Configuration registers
	logic [gsbp_pkg::CFG_DATA_W-1:0] index_bits_q;
	logic [gsbp_pkg::CFG_DATA_W-1:0] history_bits_q;

	// Global history
	logic [AW-1:0] hist_q;

	// Stage 1: counter read in flight
	logic          valid_s1;
	logic [AW-1:0] idx_s1;
	logic          taken_s1;

	// Last write, for a read that collided with it
	logic          fwd_valid_q;
	logic [AW-1:0] fwd_idx_q;
	logic [1:0]    fwd_ctr_q;

	// Output register and totals
	logic          out_valid_q;
	logic          pred_q;
	logic          ok_q;
	logic [31:0]   branch_total_q;
	logic [31:0]   correct_total_q;

	// Combinational
	logic          in_xfer;
	logic          adv_s1;
	logic          tbl_busy;
	logic [1:0]    tbl_rd_data;
	logic [CW-1:0] ib_ext;
	logic [CW-1:0] hb_ext;
	logic [CW-1:0] m_eff;
	logic [CW-1:0] n_eff;
	logic [AW-1:0] hist_m;
	logic [AW-1:0] idx_in;
	logic [AW-1:0] hist_next;
	logic [1:0]    ctr_cur;
	logic [1:0]    ctr_new;
	logic          pred_s1;
	logic          ok_s1;

	// Configuration writes always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q   <= gsbp_pkg::INDEX_BITS_RST;
			history_bits_q <= gsbp_pkg::HISTORY_BITS_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == gsbp_pkg::CFG_REG_INDEX_BITS) begin
				index_bits_q <= cfg_data;
			end else if (cfg_index == gsbp_pkg::CFG_REG_HISTORY_BITS) begin
				history_bits_q <= cfg_data;
			end
		end
	end

	// Clamp index width to [1, MAX_INDEX_BITS] and history to index width
	always_comb begin
		ib_ext = CW'(index_bits_q);
		hb_ext = CW'(history_bits_q);
		if (ib_ext == '0) begin
			m_eff = CW'(1);
		end else if (ib_ext > CW'(MAX_INDEX_BITS)) begin
			m_eff = CW'(MAX_INDEX_BITS);
		end else begin
			m_eff = ib_ext;
		end
		n_eff = (hb_ext > m_eff) ? m_eff : hb_ext;
	end

	// Table index and next history
	always_comb begin
		hist_m = hist_q & ~({AW{1'b1}} << n_eff);
		idx_in = (branch_address[AW+1:2] & ~({AW{1'b1}} << m_eff))
			^ (hist_m << (m_eff - n_eff));
		if (n_eff == '0) begin
			hist_next = '0;
		end else begin
			hist_next = (AW'(taken) << (n_eff - CW'(1))) | (hist_m >> 1);
		end
	end

	// Handshake: stage 1 moves on when the output register is free
	assign adv_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !tbl_busy && (!valid_s1 || adv_s1);
	assign in_xfer  = in_valid && in_ready;

	// Counter table
	gsbp_table #(
		.AW(AW)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_xfer),
		.rd_addr (idx_in),
		.rd_data (tbl_rd_data),
		.wr_en   (adv_s1),
		.wr_addr (idx_s1),
		.wr_data (ctr_new),
		.busy    (tbl_busy)
	);

	// Predict and update the counter
	always_comb begin
		ctr_cur = (fwd_valid_q && (fwd_idx_q == idx_s1)) ? fwd_ctr_q : tbl_rd_data;
		pred_s1 = ctr_cur[1];
		ok_s1   = (pred_s1 == taken_s1);
		if (taken_s1) begin
			ctr_new = (ctr_cur == gsbp_pkg::CTR_STRONG_T) ? ctr_cur : ctr_cur + 2'd1;
		end else begin
			ctr_new = (ctr_cur == gsbp_pkg::CTR_STRONG_NT) ? ctr_cur : ctr_cur - 2'd1;
		end
	end

	// History and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q      <= '0;
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				hist_q      <= hist_next;
				valid_s1    <= 1'b1;
				fwd_valid_q <= adv_s1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Stage 1 payload and forwarding data
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			idx_s1    <= idx_in;
			taken_s1  <= taken;
			fwd_idx_q <= idx_s1;
			fwd_ctr_q <= ctr_new;
		end
	end

	// Output register and saturating totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			branch_total_q  <= '0;
			correct_total_q <= '0;
		end else begin
			if (adv_s1) begin
				out_valid_q <= 1'b1;
				if (branch_total_q != '1) begin
					branch_total_q <= branch_total_q + 32'd1;
				end
				if (ok_s1 && (correct_total_q != '1)) begin
					correct_total_q <= correct_total_q + 32'd1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pred_q <= pred_s1;
			ok_q   <= ok_s1;
		end
	end

	assign out_valid          = out_valid_q;
	assign predicted_taken    = pred_q;
	assign prediction_correct = ok_q;
	assign branch_total       = branch_total_q;
	assign correct_total      = correct_total_q;

	// Checks
	a_no_accept_while_clearing : assert property (@(posedge clk) disable iff (!arst_n)
		tbl_busy |-> !in_ready)
		else $error("branch accepted during table clear");

	a_accept_loads_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> valid_s1)
		else $error("accepted branch did not reach stage 1");

	a_s1_from_accept : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s1) |-> $past(in_xfer))
		else $error("stage 1 loaded without a transfer");

	a_totals_order : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (correct_total <= branch_total))
		else $error("correct total exceeds branch total");

	a_out_hold : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(branch_total)))
		else $error("stalled result changed");

endmodule

`default_nettype wire

### tb/sv/gshare_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gshare_tb_pkg
// Scoreboard for the gshare branch predictor. It keeps its own counter table,
// global history and running totals. It works out the expected outcome of
// every branch transferred in and checks each result transferred out, in order.
// ----------------------------------------------------------------------------

package gshare_tb_pkg;

	import gsbp_pkg::*;

	localparam int unsigned PHT_DEPTH    = 1 << MAX_INDEX_BITS_DEF;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct packed {
		logic        predicted;
		logic        correct;
		logic [31:0] branches;
		logic [31:0] hits;
	} outcome_t;

	class gshare_scoreboard;

		logic [1:0]                    pht [PHT_DEPTH];
		logic [MAX_INDEX_BITS_DEF-1:0] ghr;
		logic [31:0]                   n_branch;
		logic [31:0]                   n_hit;
		logic [CFG_DATA_W-1:0]         index_reg;
		logic [CFG_DATA_W-1:0]         history_reg;
		outcome_t                      expected_outcomes [$];
		int unsigned                   errors;
		int unsigned                   results_seen;

		function new();
			foreach (pht[i]) pht[i] = CTR_WEAK_T;
			ghr          = '0;
			n_branch     = '0;
			n_hit        = '0;
			index_reg    = INDEX_BITS_RST;
			history_reg  = HISTORY_BITS_RST;
			errors       = 0;
			results_seen = 0;
		endfunction

		function int unsigned low_ones(int unsigned bits);
			return (32'd1 << bits) - 32'd1;
		endfunction

		// Apply a register write; unused indexes are ignored
		function void write_reg(logic [CFG_INDEX_W-1:0] idx,
				logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_REG_INDEX_BITS:   index_reg = data;
				CFG_REG_HISTORY_BITS: history_reg = data;
				default: ;
			endcase
		endfunction

		// Predict from the selected counter, then train counter, history and totals
		function void note_branch(logic [31:0] addr, logic tk);
			int unsigned m;
			int unsigned n;
			logic [MAX_INDEX_BITS_DEF-1:0] slot;
			int unsigned next_hist;
			logic [MAX_INDEX_BITS_DEF-1:0] hist;
			logic [1:0] ctr;
			outcome_t o;
			m = 32'(index_reg);
			if (m < 1) m = 1;
			if (m > MAX_INDEX_BITS_DEF) m = MAX_INDEX_BITS_DEF;
			n = 32'(history_reg);
			if (n > m) n = m;

			hist = ghr & MAX_INDEX_BITS_DEF'(low_ones(n));
			slot = MAX_INDEX_BITS_DEF'(((addr >> 2) & low_ones(m)) ^ (32'(hist) << (m - n)));

			ctr = pht[slot];
			o.predicted = (ctr >= CTR_WEAK_T);
			o.correct   = (o.predicted == tk);
			if (tk && ctr != CTR_STRONG_T)
				ctr = ctr + 2'd1;
			else if (!tk && ctr != CTR_STRONG_NT)
				ctr = ctr - 2'd1;
			pht[slot] = ctr;

			// newest outcome enters at the top in-use bit
			if (n == 0)
				next_hist = 0;
			else
				next_hist = (32'(tk) << (n - 1)) | (32'(hist) >> 1);
			ghr = next_hist[MAX_INDEX_BITS_DEF-1:0];

			if (n_branch != '1) n_branch = n_branch + 1;
			if (o.correct && n_hit != '1) n_hit = n_hit + 1;
			o.branches = n_branch;
			o.hits     = n_hit;
			expected_outcomes.push_back(o);
		endfunction

		// Compare one result with the oldest outcome waiting
		function void check_result(logic pred, logic ok, logic [31:0] bt, logic [31:0] ct);
			outcome_t want;
			results_seen++;
			if (expected_outcomes.size() == 0) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("result %0d arrived with no branch pending: %s",
						results_seen,
						$sformatf("pred=%b ok=%b totals=%0d/%0d", pred, ok, bt, ct));
				return;
			end
			want = expected_outcomes.pop_front();
			if (pred !== want.predicted || ok !== want.correct ||
				bt !== want.branches || ct !== want.hits) begin
				errors++;
				if (errors <= REPORT_LIMIT)
					$display("result %0d mismatch: expected %s, got %s",
						results_seen,
						$sformatf("pred=%b ok=%b totals=%0d/%0d",
							want.predicted, want.correct, want.branches, want.hits),
						$sformatf("pred=%b ok=%b totals=%0d/%0d", pred, ok, bt, ct));
			end
		endfunction

	endclass

endpackage

### tb/sv/tb_gshare_branch_predictor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gshare_branch_predictor
// Drives resolved branches through the gshare predictor under several index
// and history widths. Directed branches cover address extremes, counter
// saturation, out-of-range and clamped widths. Random phases replay loop-like
// outcome patterns on a few hot addresses, mixed with noise. Both handshakes
// idle at random; every result is checked against the scoreboard.
// ----------------------------------------------------------------------------

module tb_gshare_branch_predictor;

	import gsbp_pkg::*;
	import gshare_tb_pkg::*;

	localparam int CLK_PERIOD_NS  = 8;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int RX_HOLD_CYCLES = 64;
	localparam int IDLE_PCT       = 28;

	// indexes with no register behind them
	localparam logic [CFG_INDEX_W-1:0] CFG_REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_REG_SPARE_B = 2'd3;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [31:0]            branch_address = '0;
	logic                   taken = 1'b0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   predicted_taken;
	logic                   prediction_correct;
	logic [31:0]            branch_total;
	logic [31:0]            correct_total;

	// no random idling on either side while set
	bit calm = 1'b0;
	// one long receiver hold-off, requested by the stimulus
	bit rx_hold_req = 1'b0;

	gshare_scoreboard sb = new();

	gshare_branch_predictor dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.branch_address     (branch_address),
		.taken              (taken),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.predicted_taken    (predicted_taken),
		.prediction_correct (prediction_correct),
		.branch_total       (branch_total),
		.correct_total      (correct_total)
	);

	always #(CLK_PERIOD_NS / 2) clk = ~clk;

	// Observe every transfer at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (out_valid && out_ready)
				sb.check_result(predicted_taken, prediction_correct, branch_total, correct_total);
			if (in_valid && in_ready)
				sb.note_branch(branch_address, taken);
		end
	end

	// Result side: random back-pressure, one long hold-off on request
	initial begin : rx_side
		int unsigned hold_left;
		bit held;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req && !held) begin
				held = 1'b1;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (calm) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Write one register; valid stays high for a following write
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_widths(input int unsigned ib, input int unsigned hb);
		write_reg(CFG_REG_INDEX_BITS, CFG_DATA_W'(ib));
		write_reg(CFG_REG_HISTORY_BITS, CFG_DATA_W'(hb));
		cfg_valid <= 1'b0;
	endtask

	// Offer one branch, with random idle cycles ahead of it
	task automatic send_branch(input logic [31:0] addr, input logic tk);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		branch_address <= addr;
		taken          <= tk;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Stop offering and wait until every outcome has been checked
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.expected_outcomes.size() != 0)
			@(negedge clk);
	endtask

	// Random phase: mostly periodic outcomes on a few hot addresses, some noise
	task automatic run_phase(input int unsigned ib, input int unsigned hb, input int n_items,
			input bit quiet, input int hold_at, input int pause_at);
		logic [31:0] hot [6];
		int unsigned period [6];
		int unsigned seen [6];
		logic [31:0] base;
		logic [31:0] addr;
		logic tk;
		logic [2:0] k;
		set_widths(ib, hb);
		base = $urandom;
		foreach (hot[j]) begin
			// half share a small region so table entries collide through history
			hot[j] = (j < 3) ? base + 32'(4 * $urandom_range(15)) : $urandom;
			period[j] = $urandom_range(1, 6);
			seen[j] = 0;
		end
		calm = quiet;
		for (int i = 0; i < n_items; i++) begin
			if (i == hold_at) rx_hold_req = 1'b1;
			if (i == pause_at) wait_drained();
			if ($urandom_range(99) < 80) begin
				k = 3'($urandom_range(5));
				addr = hot[k];
				tk = ((seen[k] % period[k]) != period[k] - 1);
				if ($urandom_range(99) < 5) tk = ~tk;
				seen[k]++;
			end else begin
				addr = $urandom;
				tk = 1'($urandom_range(1));
			end
			send_branch(addr, tk);
		end
		wait_drained();
		calm = 1'b0;
	endtask

	initial begin : stimulus
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset widths first
		send_branch(32'h0000_0000, 1'b1);
		send_branch(32'hFFFF_FFFF, 1'b0);
		send_branch(32'h1234_5678, 1'b1);
		wait_drained();

		// no history: walk one counter up to strong taken and down to strong not taken
		set_widths(12, 0);
		repeat (4) send_branch(32'h0000_0000, 1'b1);
		repeat (5) send_branch(32'h0000_0000, 1'b0);
		send_branch(32'hFFFF_FFFF, 1'b1);
		send_branch(32'hFFFF_FFFC, 1'b0);
		wait_drained();

		// spare indexes, then zero index width with history clamped to it
		write_reg(CFG_REG_SPARE_A, 4'hF);
		write_reg(CFG_REG_SPARE_B, 4'h0);
		set_widths(0, 15);
		send_branch(32'h0000_0004, 1'b1);
		send_branch(32'h0000_0004, 1'b0);
		send_branch(32'hAAAA_AAAA, 1'b1);
		send_branch(32'h5555_5555, 1'b1);
		wait_drained();

		// both widths at the top of their fields
		set_widths(15, 15);
		send_branch(32'h0000_3FFC, 1'b1);
		send_branch(32'h0000_3FFC, 1'b1);
		send_branch(32'hFFFF_C000, 1'b0);
		send_branch(32'h8000_0000, 1'b1);
		wait_drained();

		// index width just above the table size
		set_widths(13, 3);
		send_branch(32'h7FFF_FFFF, 1'b0);
		send_branch(32'h0000_0010, 1'b1);
		send_branch(32'h0000_0010, 1'b0);
		wait_drained();

		run_phase(12, 12, 110, 1'b0, -1, -1);
		run_phase(12, 0, 100, 1'b0, -1, -1);
		run_phase(4, 2, 120, 1'b1, -1, -1);
		run_phase(1, 1, 90, 1'b0, -1, -1);
		run_phase(15, 15, 120, 1'b0, 30, -1);
		run_phase(0, 0, 80, 1'b0, -1, -1);
		run_phase($urandom_range(15), $urandom_range(15), 120, 1'b0, -1, 50);
		run_phase(7, 12, 110, 1'b0, -1, -1);
		run_phase($urandom_range(15), $urandom_range(15), 120, 1'b0, -1, -1);

		// let any stray result show up
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_outcomes.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin : watchdog
		#(CLK_PERIOD_NS * TIMEOUT_CYCLES);
		$display("TB_ERROR");
		$finish;
	end

endmodule

### files.f
rtl/gsbp_pkg.sv
rtl/gsbp_table.sv
rtl/gshare_branch_predictor.sv
tb/sv/gshare_tb_pkg.sv
tb/sv/tb_gshare_branch_predictor.sv
